### hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, off during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tvg_pkg.sv
package tvg_pkg;

  localparam int PosW = 24;
  localparam int AngW = 18;
  localparam int HeadW = 17;
  localparam int ColW = 8;
  // cordic datapath width: position plus 6 guard fraction bits plus growth
  localparam int CorW = 34;
  localparam int ZW = 24;
  localparam int AtanCount = 24;
  localparam int CordicIterationsDefault = 16;

  localparam logic [HeadW-1:0] FullTurn = 17'd92160;
  localparam logic [HeadW-1:0] QuarterTurn = 17'd23040;
  localparam logic signed [31:0] InvGainQ30 = 32'sd652032874;

  typedef enum logic [2:0] {
    KIND_FWD      = 3'd0,
    KIND_LEFT     = 3'd1,
    KIND_RIGHT    = 3'd2,
    KIND_PEN_UP   = 3'd3,
    KIND_PEN_DOWN = 3'd4,
    KIND_GOTO     = 3'd5,
    KIND_FILL     = 3'd6
  } kind_t;

  localparam logic [1:0] REG_RED = 2'd0;
  localparam logic [1:0] REG_GREEN = 2'd1;
  localparam logic [1:0] REG_BLUE = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture input beat and prepare
    logic turn_left;
    logic turn_right;
    logic cordic_init;
    logic cordic_step;
    logic finish_move;
    logic do_goto;
    logic out_load;
    logic out_fill;
  } tvg_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic cordic_last;
  } tvg_stat_t;

  function automatic logic [ZW-1:0] atan_lookup(input logic [4:0] i);
    logic [ZW-1:0] r;
    case (i)
      5'd0: r = 24'd2949120;
      5'd1: r = 24'd1740967;
      5'd2: r = 24'd919879;
      5'd3: r = 24'd466945;
      5'd4: r = 24'd234379;
      5'd5: r = 24'd117304;
      5'd6: r = 24'd58666;
      5'd7: r = 24'd29335;
      5'd8: r = 24'd14668;
      5'd9: r = 24'd7334;
      5'd10: r = 24'd3667;
      5'd11: r = 24'd1833;
      5'd12: r = 24'd917;
      5'd13: r = 24'd458;
      5'd14: r = 24'd229;
      5'd15: r = 24'd115;
      5'd16: r = 24'd57;
      5'd17: r = 24'd29;
      5'd18: r = 24'd14;
      5'd19: r = 24'd7;
      5'd20: r = 24'd4;
      5'd21: r = 24'd2;
      5'd22: r = 24'd1;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage

### hdl/tvg_ctrl.sv
module tvg_ctrl
  import tvg_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [2:0]      in_kind,
  input  logic            pen_down,
  input  logic            out_busy,
  input  tvg_stat_t       stat,
  output logic            in_ready,
  output tvg_cmd_t        cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREP   = 5'b00010,
    S_CORDIC = 5'b00100,
    S_FINISH = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [2:0] kind, kind_next;
  logic emit_pen;

  assign in_ready = (state == S_IDLE);
  assign emit_pen = pen_down;

  // next state and commands
  always_comb begin
    state_next = state;
    kind_next = kind;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          kind_next = in_kind;
          cmd.load = 1'b1;
          case (in_kind)
            KIND_LEFT: cmd.turn_left = 1'b1;
            KIND_RIGHT: cmd.turn_right = 1'b1;
            KIND_FWD, KIND_FILL: state_next = S_PREP;
            KIND_GOTO: begin
              cmd.do_goto = 1'b1;
              if (emit_pen) state_next = S_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_PREP: begin
        cmd.cordic_init = 1'b1;
        state_next = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (stat.cordic_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish_move = 1'b1;
        if (kind == KIND_FILL || emit_pen) state_next = S_EMIT;
        else state_next = S_IDLE;
      end
      S_EMIT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_fill = (kind == KIND_FILL);
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind <= '0;
    end else begin
      state <= state_next;
      kind <= kind_next;
    end
  end

endmodule

### hdl/tvg_datapath.sv
module tvg_datapath
  import tvg_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CordicIterationsDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tvg_cmd_t                 cmd,
  input  logic [2:0]               in_kind,
  input  logic signed [PosW-1:0]   in_distance,
  input  logic signed [AngW-1:0]   in_angle,
  input  logic signed [PosW-1:0]   in_target_x,
  input  logic signed [PosW-1:0]   in_target_y,
  output tvg_stat_t                stat,
  output logic                     pen_down,
  output logic signed [PosW-1:0]   seg_sx,
  output logic signed [PosW-1:0]   seg_sy,
  output logic signed [PosW-1:0]   pos_x,
  output logic signed [PosW-1:0]   pos_y
);

  localparam int IterW = $clog2(CORDIC_ITERATIONS + 1);

  logic [HeadW-1:0] heading;
  logic [HeadW-1:0] turn_amt;
  logic [AngW:0] ang_red;
  logic [HeadW:0] head_sum;
  logic [1:0] quad;
  logic [HeadW-1:0] resid;
  logic signed [PosW-1:0] dist_q;
  logic signed [CorW+23:0] prod;
  logic signed [CorW-1:0] cx, cy;
  logic signed [ZW+1:0] cz;
  logic [IterW-1:0] iter;
  logic signed [CorW-1:0] xs, ys;
  logic signed [CorW-1:0] dx, dy;
  logic signed [CorW-1:0] rx, ry;
  logic signed [CorW:0] nx, ny;

  // reduce a signed angle to 0..FullTurn-1 (range is within two turns)
  always_comb begin
    logic signed [AngW:0] a;
    a = {in_angle[AngW-1], in_angle};
    if (a < 0) a = a + $signed({2'b00, FullTurn});
    if (a < 0) a = a + $signed({2'b00, FullTurn});
    if (a >= $signed({2'b00, FullTurn})) a = a - $signed({2'b00, FullTurn});
    if (a >= $signed({2'b00, FullTurn})) a = a - $signed({2'b00, FullTurn});
    ang_red = a;
    turn_amt = a[HeadW-1:0];
  end

  // heading update for turns
  always_comb begin
    if (cmd.turn_left) head_sum = {1'b0, heading} + {1'b0, turn_amt};
    else head_sum = {1'b0, heading} + {1'b0, FullTurn} - {1'b0, turn_amt};
    if (head_sum >= {1'b0, FullTurn}) head_sum = head_sum - {1'b0, FullTurn};
  end

  // quadrant split of the heading
  always_comb begin
    if (heading >= 3 * QuarterTurn) begin
      quad = 2'd3; resid = heading - 17'(3 * QuarterTurn);
    end else if (heading >= 2 * QuarterTurn) begin
      quad = 2'd2; resid = heading - 17'(2 * QuarterTurn);
    end else if (heading >= QuarterTurn) begin
      quad = 2'd1; resid = heading - QuarterTurn;
    end else begin
      quad = 2'd0; resid = heading;
    end
  end

  assign prod = dist_q * InvGainQ30 + 58'sd8388608;
  assign xs = cx >>> iter;
  assign ys = cy >>> iter;
  assign stat.cordic_last = (iter == IterW'(CORDIC_ITERATIONS - 1));

  // exact quarter-turn rotation and rounding
  always_comb begin
    case (quad)
      2'd0: begin rx = cx; ry = cy; end
      2'd1: begin rx = -cy; ry = cx; end
      2'd2: begin rx = -cx; ry = -cy; end
      default: begin rx = cy; ry = -cx; end
    endcase
    dx = (rx + CorW'(32)) >>> 6;
    dy = (ry + CorW'(32)) >>> 6;
    nx = {pos_x[PosW-1], {(CorW-PosW){pos_x[PosW-1]}}, pos_x} + {dx[CorW-1], dx};
    ny = {pos_y[PosW-1], {(CorW-PosW){pos_y[PosW-1]}}, pos_y} + {dy[CorW-1], dy};
  end

  function automatic logic signed [PosW-1:0] sat(input logic signed [CorW:0] v);
    if (v > $signed((CorW+1)'(8388607))) return 24'sh7fffff;
    if (v < -$signed((CorW+1)'(8388608))) return 24'sh800000;
    return v[PosW-1:0];
  endfunction

  // turtle state
  always_ff @(posedge clk) begin
    if (rst) begin
      heading <= '0;
      pen_down <= 1'b1;
      pos_x <= '0;
      pos_y <= '0;
    end else begin
      if (cmd.turn_left || cmd.turn_right) heading <= head_sum[HeadW-1:0];
      if (cmd.load && in_kind == KIND_PEN_UP) pen_down <= 1'b0;
      if (cmd.load && in_kind == KIND_PEN_DOWN) pen_down <= 1'b1;
      if (cmd.do_goto) begin
        pos_x <= in_target_x;
        pos_y <= in_target_y;
        heading <= '0;
      end
      if (cmd.finish_move) begin
        pos_x <= sat(nx);
        pos_y <= sat(ny);
      end
    end
  end

  // segment start and cordic registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seg_sx <= pos_x;
      seg_sy <= pos_y;
      dist_q <= in_distance;
    end
    if (cmd.cordic_init) begin
      cx <= prod[CorW+23:24];
      cy <= '0;
      cz <= $signed({1'b0, resid, 8'd0});
      iter <= '0;
    end else if (cmd.cordic_step) begin
      if (!cz[ZW+1]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - $signed({2'b00, atan_lookup(5'(iter))});
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + $signed({2'b00, atan_lookup(5'(iter))});
      end
      iter <= iter + 1'b1;
    end
  end

  logic unused_ok;
  assign unused_ok = ^ang_red[AngW];

endmodule

### hdl/turtle_vector_generator.sv
// Turtle vector generator: one command per input beat. Turns, pen changes and
// go-to complete as the beat is taken; a go-to with the pen down then presents
// its segment from the emit state. A forward or forward-fill move runs an
// iterative CORDIC, one rotation step a cycle, through the prepare, CORDIC and
// finish states, then the emit state if it presents a segment. The input stays
// stalled while a segment waits on a held output register. The user writes the
// pen color registers via the write port only while idle; the block won't check.
module turtle_vector_generator
  import tvg_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CordicIterationsDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [ColW-1:0]         cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              kind,
  input  logic signed [PosW-1:0]  distance,
  input  logic signed [AngW-1:0]  angle,
  input  logic signed [PosW-1:0]  target_x,
  input  logic signed [PosW-1:0]  target_y,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [PosW-1:0]  start_x,
  output logic signed [PosW-1:0]  start_y,
  output logic signed [PosW-1:0]  end_x,
  output logic signed [PosW-1:0]  end_y,
  output logic [ColW-1:0]         seg_red,
  output logic [ColW-1:0]         seg_green,
  output logic [ColW-1:0]         seg_blue,
  output logic                    is_fill
);

`include "assert_macros.svh"

  tvg_cmd_t cmd;
  tvg_stat_t stat;
  logic in_ready;
  logic pen_down;
  logic out_busy;
  logic [ColW-1:0] pen_red, pen_green, pen_blue;
  logic signed [PosW-1:0] seg_sx, seg_sy, pos_x, pos_y;

  assign in_stall = !in_ready;
  assign out_busy = out_valid && out_stall;

  // pen color registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_red <= '0;
      pen_green <= '0;
      pen_blue <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RED: pen_red <= cfg_data;
        REG_GREEN: pen_green <= cfg_data;
        REG_BLUE: pen_blue <= cfg_data;
        default: ;
      endcase
    end
  end

  tvg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_kind(kind),
    .pen_down(pen_down), .out_busy(out_busy), .stat(stat),
    .in_ready(in_ready), .cmd(cmd)
  );

  tvg_datapath #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_kind(kind), .in_distance(distance),
    .in_angle(angle), .in_target_x(target_x), .in_target_y(target_y),
    .stat(stat), .pen_down(pen_down), .seg_sx(seg_sx), .seg_sy(seg_sy),
    .pos_x(pos_x), .pos_y(pos_y)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      start_x <= seg_sx;
      start_y <= seg_sy;
      end_x <= pos_x;
      end_y <= pos_y;
      seg_red <= pen_red;
      seg_green <= pen_green;
      seg_blue <= pen_blue;
      is_fill <= cmd.out_fill;
    end
  end

  `ASSERT_IMPL(a_no_overwrite, clk, rst, out_busy, !cmd.out_load, "result overwritten")
  `ASSERT_NEXT(a_load_shows, clk, rst, cmd.out_load, out_valid, "loaded beat not shown")
  `ASSERT_IMPL(a_busy_no_accept, clk, rst, cmd.cordic_step, in_stall, "accept during move")

endmodule

### sim/turtle_vector_generator_test.sv
`timescale 1ns / 100ps

module turtle_vector_generator_test;
  import tvg_pkg::*;

  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 750;

  typedef struct packed {
    logic signed [PosW-1:0] sx;
    logic signed [PosW-1:0] sy;
    logic signed [PosW-1:0] ex;
    logic signed [PosW-1:0] ey;
    logic [ColW-1:0] r;
    logic [ColW-1:0] g;
    logic [ColW-1:0] b;
    logic fill;
  } segment_t;

  typedef struct packed {
    logic [2:0] k;
    logic signed [PosW-1:0] d;
    logic signed [AngW-1:0] a;
    logic signed [PosW-1:0] tx;
    logic signed [PosW-1:0] ty;
    logic typed;
    segment_t seg;
  } command_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [ColW-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [2:0] kind;
  logic signed [PosW-1:0] distance;
  logic signed [AngW-1:0] angle;
  logic signed [PosW-1:0] target_x;
  logic signed [PosW-1:0] target_y;
  logic out_valid;
  logic out_stall;
  logic signed [PosW-1:0] start_x;
  logic signed [PosW-1:0] start_y;
  logic signed [PosW-1:0] end_x;
  logic signed [PosW-1:0] end_y;
  logic [ColW-1:0] seg_red;
  logic [ColW-1:0] seg_green;
  logic [ColW-1:0] seg_blue;
  logic is_fill;

  turtle_vector_generator DUT (.*);

  // turtle state mirror
  longint turtle_x, turtle_y;
  int turtle_heading;
  bit turtle_pen;
  logic [ColW-1:0] pen_r, pen_g, pen_b;

  segment_t pending_segments[$];
  int mismatches;
  int segments_seen;
  int fill_seen;
  int commands_sent;
  bit hold_request;

  localparam longint AtanDeg[24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  function automatic longint clamp_pos(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // cordic rotation of the distance by the heading, then position update
  function automatic void step_turtle(input longint move_len);
    int quad;
    longint z, x, y, xs, ys, dx, dy;
    quad = turtle_heading / 23040;
    z = longint'(turtle_heading - quad * 23040) * 256;
    x = (move_len * 64'sd652032874 + (64'sd1 <<< 23)) >>> 24;
    y = 0;
    for (int i = 0; i < CordicIterationsDefault; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= AtanDeg[i];
      end else begin
        x += ys; y -= xs; z += AtanDeg[i];
      end
    end
    case (quad)
      0: begin dx = x; dy = y; end
      1: begin dx = -y; dy = x; end
      2: begin dx = -x; dy = -y; end
      default: begin dx = y; dy = -x; end
    endcase
    turtle_x = clamp_pos(turtle_x + ((dx + 32) >>> 6));
    turtle_y = clamp_pos(turtle_y + ((dy + 32) >>> 6));
  endfunction

  // apply one command, returns 1 with the segment if one is drawn
  function automatic bit run_command(input logic [2:0] k, input logic signed [PosW-1:0] d,
                                     input logic signed [AngW-1:0] a,
                                     input logic signed [PosW-1:0] tx,
                                     input logic signed [PosW-1:0] ty,
                                     output segment_t seg);
    longint sx, sy;
    int turn;
    bit drawn;
    sx = turtle_x;
    sy = turtle_y;
    turn = ((int'(a) % 92160) + 92160) % 92160;
    drawn = 0;
    case (k)
      KIND_FWD: begin step_turtle(d); drawn = turtle_pen; end
      KIND_LEFT: turtle_heading = (turtle_heading + turn) % 92160;
      KIND_RIGHT: turtle_heading = (turtle_heading + 92160 - turn) % 92160;
      KIND_PEN_UP: turtle_pen = 0;
      KIND_PEN_DOWN: turtle_pen = 1;
      KIND_GOTO: begin
        turtle_x = tx; turtle_y = ty; turtle_heading = 0; drawn = turtle_pen;
      end
      KIND_FILL: begin step_turtle(d); drawn = 1; end
      default: ;
    endcase
    seg.sx = sx[PosW-1:0];
    seg.sy = sy[PosW-1:0];
    seg.ex = turtle_x[PosW-1:0];
    seg.ey = turtle_y[PosW-1:0];
    seg.r = pen_r;
    seg.g = pen_g;
    seg.b = pen_b;
    seg.fill = (k == KIND_FILL);
    return drawn;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("turtle_vector_generator: mismatch");
    $finish;
  end

  // receiver stall pattern, with one long hold on request
  initial begin
    int mode, left;
    out_stall = 0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 120);
        end
        left--;
        case (mode)
          0: out_stall <= 0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (left % 4 == 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    segment_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{start_x, start_y, end_x, end_y, seg_red, seg_green, seg_blue, is_fill};
      segments_seen++;
      if (got.fill) fill_seen++;
      if (pending_segments.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected segment %p", got);
      end else begin
        want = pending_segments.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("segment differs: expected %p, got %p", want, got);
        end
      end
    end
  end

  // offer one command beat and wait for acceptance
  task automatic send_command(input logic [2:0] k, input logic signed [PosW-1:0] d,
                              input logic signed [AngW-1:0] a,
                              input logic signed [PosW-1:0] tx,
                              input logic signed [PosW-1:0] ty,
                              input bit typed, input segment_t typed_seg);
    segment_t seg;
    in_valid <= 1;
    kind <= k;
    distance <= d;
    angle <= a;
    target_x <= tx;
    target_y <= ty;
    do @(posedge clk); while (in_stall);
    commands_sent++;
    if (run_command(k, d, a, tx, ty, seg)) pending_segments.push_back(typed ? typed_seg : seg);
  endtask

  // wait for all segments, then for a pen-up move still in flight
  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_pen(input logic [ColW-1:0] r, input logic [ColW-1:0] g,
                         input logic [ColW-1:0] b);
    cfg_we <= 1;
    cfg_index <= REG_RED; cfg_data <= r; @(posedge clk);
    cfg_index <= REG_GREEN; cfg_data <= g; @(posedge clk);
    cfg_index <= REG_BLUE; cfg_data <= b; @(posedge clk);
    cfg_index <= REG_SPARE; cfg_data <= ColW'($urandom); @(posedge clk);
    cfg_we <= 0;
    pen_r = r;
    pen_g = g;
    pen_b = b;
  endtask

  // stimulus
  initial begin
    command_row_t directed[23];
    int burst, pick;
    logic [2:0] k;
    logic signed [PosW-1:0] d, tx, ty;
    logic signed [AngW-1:0] a;

    directed = '{
      '{KIND_FWD, 0, 0, 0, 0, 1'b1, '0},
      '{KIND_GOTO, 0, 0, 8388607, -8388608, 1'b1,
        '{0, 0, 8388607, -8388608, 8'd0, 8'd0, 8'd0, 1'b0}},
      '{KIND_GOTO, 0, 0, -8388608, 8388607, 1'b1,
        '{8388607, -8388608, -8388608, 8388607, 8'd0, 8'd0, 8'd0, 1'b0}},
      '{KIND_FWD, -8388608, 0, 0, 0, 1'b0, '0},
      '{KIND_LEFT, 0, 92160, 0, 0, 1'b0, '0},
      '{KIND_LEFT, 0, -92160, 0, 0, 1'b0, '0},
      '{KIND_RIGHT, 0, 11520, 0, 0, 1'b0, '0},
      '{KIND_FWD, 25600, 0, 0, 0, 1'b0, '0},
      '{KIND_LEFT, 0, 92159, 0, 0, 1'b0, '0},
      '{KIND_RIGHT, 0, -92160, 0, 0, 1'b0, '0},
      '{KIND_PEN_UP, 0, 0, 0, 0, 1'b0, '0},
      '{KIND_FWD, 5000, 0, 0, 0, 1'b0, '0},
      '{KIND_GOTO, 0, 0, 1000, -1000, 1'b0, '0},
      '{KIND_FILL, -3000, 0, 0, 0, 1'b0, '0},
      '{KIND_UNUSED, 8388607, -92160, -1, -1, 1'b0, '0},
      '{KIND_PEN_DOWN, 0, 0, 0, 0, 1'b0, '0},
      '{KIND_LEFT, 0, 23040, 0, 0, 1'b0, '0},
      '{KIND_FWD, 12345, 0, 0, 0, 1'b0, '0},
      '{KIND_LEFT, 0, 23040, 0, 0, 1'b0, '0},
      '{KIND_FWD, 8388607, 0, 0, 0, 1'b0, '0},
      '{KIND_LEFT, 0, 23040, 0, 0, 1'b0, '0},
      '{KIND_FILL, 8388607, 0, 0, 0, 1'b0, '0},
      '{KIND_FWD, 0, 0, 0, 0, 1'b0, '0}
    };

    rst = 1;
    cfg_we = 0; cfg_index = REG_RED; cfg_data = 0;
    in_valid = 0; kind = KIND_FWD; distance = 0; angle = 0; target_x = 0; target_y = 0;
    hold_request = 0;
    turtle_x = 0; turtle_y = 0; turtle_heading = 0; turtle_pen = 1;
    pen_r = 0; pen_g = 0; pen_b = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed table with reset colors
    foreach (directed[i])
      send_command(directed[i].k, directed[i].d, directed[i].a, directed[i].tx,
                   directed[i].ty, directed[i].typed, directed[i].seg);
    drain();
    set_pen(8'hff, 8'h00, 8'hff);

    // random commands in bursts
    burst = $urandom_range(1, 16);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 250) begin drain(); set_pen(8'h00, 8'hff, 8'h00); end
      if (n == 500) begin
        drain();
        set_pen(ColW'($urandom), ColW'($urandom), ColW'($urandom));
      end
      if (n == 380) drain();
      if (n == 150) hold_request = 1;
      pick = $urandom_range(0, 99);
      if (pick < 35) k = KIND_FWD;
      else if (pick < 50) k = KIND_FILL;
      else if (pick < 60) k = KIND_LEFT;
      else if (pick < 70) k = KIND_RIGHT;
      else if (pick < 77) k = KIND_PEN_UP;
      else if (pick < 87) k = KIND_PEN_DOWN;
      else if (pick < 97) k = KIND_GOTO;
      else k = KIND_UNUSED;
      d = ($urandom_range(0, 3) == 0) ? PosW'($urandom)
                                      : PosW'(int'($urandom_range(0, 8192)) - 4096);
      a = AngW'(int'($urandom_range(0, 184320)) - 92160);
      tx = ($urandom_range(0, 2) == 0) ? PosW'($urandom)
                                       : PosW'(int'($urandom_range(0, 200000)) - 100000);
      ty = ($urandom_range(0, 2) == 0) ? PosW'($urandom)
                                       : PosW'(int'($urandom_range(0, 200000)) - 100000);
      send_command(k, d, a, tx, ty, 1'b0, '0);
      burst--;
      if (burst == 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst = $urandom_range(1, 16);
      end
    end
    in_valid <= 0;

    // wait for the tail
    for (int t = 0; t < 20000 && pending_segments.size() != 0; t++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_segments.size() != 0) mismatches += pending_segments.size();

    $display("ran %0d commands through four pen color settings", commands_sent);
    $display("checked %0d segments, %0d of them fill edges", segments_seen, fill_seen);
    if (mismatches == 0) begin
      $display("turtle_vector_generator: match");
    end else begin
      $display("turtle_vector_generator: mismatch");
    end
    $finish;
  end

endmodule
